FILE: hw/rtl/kpd_pkg.sv
`timescale 1ns / 1ps

package kpd_pkg;

	localparam int NUM_KEYS  = 7;
	localparam int KEY_W     = $clog2(NUM_KEYS);
	localparam int MAP_W     = 32;
	localparam int CODE_W    = 16;
	localparam int SCAN_W    = 8;
	localparam int ROW_W     = 16;
	localparam int CFG_ADDR_W = 3;

	// register indexes on the config port
	localparam logic [CFG_ADDR_W-1:0] REG_KEY_MODE = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_MAP_BASE = 3'd1;

	// modifier request bits inside a mapped code
	localparam int SHIFT_BIT = 15;
	localparam int FUNC_BIT  = 14;
	localparam int CTRL_BIT  = 13;
	localparam logic [CODE_W-1:0] STD_MASK = 16'h1FFF;

	// row marker bits ORed into the scan code
	localparam logic [SCAN_W-1:0] ROW1_BIT = 8'h20;
	localparam logic [SCAN_W-1:0] ROW2_BIT = 8'h40;
	localparam logic [SCAN_W-1:0] ROW3_BIT = 8'h80;

	// buttons in test order: up, right, left, down, centre, soft left, soft right
	localparam logic [NUM_KEYS-1:0][SCAN_W-1:0] TEST_PATTERN = {
		8'h41, 8'h81, 8'h30, 8'h28, 8'h24, 8'h22, 8'h21
	};
	localparam logic [NUM_KEYS-1:0][KEY_W-1:0] TEST_KEY = {
		3'd6, 3'd5, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0
	};

	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_SHIFT = 2'd1,
		KIND_CTRL  = 2'd2,
		KIND_FUNC  = 2'd3
	} kind_t;

	typedef logic [NUM_KEYS-1:0][MAP_W-1:0] key_map_t;

	// one tick's edges, indexed by test position
	typedef struct packed {
		logic [NUM_KEYS-1:0] hit;
		logic [NUM_KEYS-1:0] press;
	} edge_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hw/rtl/kpd_front.sv
`timescale 1ns / 1ps

module kpd_front
	import kpd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic [ROW_W-1:0]    row_one,
	input  logic [ROW_W-1:0]    row_two,
	input  logic [ROW_W-1:0]    row_three,
	output logic                push,
	output edge_word_t          push_word,
	output logic [NUM_KEYS-1:0] pressed
);

	logic [NUM_KEYS-1:0] pressed_q;
	logic [NUM_KEYS-1:0] pressed_nxt;
	logic [SCAN_W-1:0]   scan;
	logic [NUM_KEYS-1:0] now;
	logic [NUM_KEYS-1:0] was;

	// last nonzero row wins
	always_comb begin
		if (row_three != '0) begin
			scan = row_three[SCAN_W-1:0] | ROW3_BIT;
		end else if (row_two != '0) begin
			scan = row_two[SCAN_W-1:0] | ROW2_BIT;
		end else if (row_one != '0) begin
			scan = row_one[SCAN_W-1:0] | ROW1_BIT;
		end else begin
			scan = '0;
		end
	end

	always_comb begin
		pressed_nxt = pressed_q;
		for (int i = 0; i < NUM_KEYS; i++) begin
			now[i] = (scan & TEST_PATTERN[i]) == TEST_PATTERN[i];
			was[i] = pressed_q[TEST_KEY[i]];
			pressed_nxt[TEST_KEY[i]] = now[i];
		end
	end

	assign push_word.hit   = now ^ was;
	assign push_word.press = now;
	assign push            = accept && (push_word.hit != '0);
	assign pressed         = pressed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressed_q <= '0;
		end else if (accept) begin
			pressed_q <= pressed_nxt;
		end
	end

endmodule

FILE: hw/rtl/kpd_fifo.sv
`timescale 1ns / 1ps

module kpd_fifo
	import kpd_pkg::*;
#(
	parameter int DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  edge_word_t push_word,
	input  logic       pop,
	output edge_word_t head,
	output q_stat_t    stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	edge_word_t       mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (count_q == FULL_CNT);
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/kpd_back.sv
`timescale 1ns / 1ps

module kpd_back
	import kpd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        key_mode,
	input  key_map_t    key_map,
	input  edge_word_t  head,
	input  q_stat_t     stat,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output kind_t       out_kind,
	output logic [7:0]  out_code,
	output logic        out_down,
	output logic        out_last
);

	logic [NUM_KEYS-1:0] hit_q;
	logic [NUM_KEYS-1:0] press_q;
	logic [3:0]          sub_q;
	logic                sub_vld_q;
	logic                out_valid_q;
	kind_t               out_kind_q;
	logic [7:0]          out_code_q;
	logic                out_down_q;
	logic                out_last_q;

	logic [KEY_W-1:0]    idx;
	logic [KEY_W-1:0]    key;
	logic [CODE_W-1:0]   code;
	logic                press;
	logic [3:0]          fresh;
	logic [3:0]          mask;
	logic [3:0]          low;
	logic [3:0]          rest;
	logic [NUM_KEYS-1:0] hit_nxt;
	logic                last;
	logic                adv;
	kind_t               kind;

	// lowest pending edge in test order
	always_comb begin
		idx = '0;
		for (int i = NUM_KEYS - 1; i >= 0; i--) begin
			if (hit_q[i]) begin
				idx = KEY_W'(i);
			end
		end
	end

	assign key   = TEST_KEY[idx];
	assign code  = key_mode ? key_map[key][MAP_W-1:CODE_W] : key_map[key][CODE_W-1:0];
	assign press = press_q[idx];

	// event slots in emission order, bit 0 first
	assign fresh = press ? {1'b1, code[FUNC_BIT], code[CTRL_BIT], code[SHIFT_BIT]}
	                     : {code[SHIFT_BIT], code[CTRL_BIT], code[FUNC_BIT], 1'b1};
	assign mask  = sub_vld_q ? sub_q : fresh;
	assign low   = mask & (~mask + 4'd1);
	assign rest  = mask & ~low;

	always_comb begin
		hit_nxt = hit_q;
		if (rest == '0) begin
			hit_nxt[idx] = 1'b0;
		end
	end

	assign last = (rest == '0) && (hit_nxt == '0);
	assign adv  = (hit_q != '0) && (!out_valid_q || out_ready);
	assign pop  = !stat.empty && ((hit_q == '0) || (adv && last));

	always_comb begin
		case (low)
			4'b0001: kind = press ? KIND_SHIFT : KIND_KEY;
			4'b0010: kind = press ? KIND_CTRL  : KIND_FUNC;
			4'b0100: kind = press ? KIND_FUNC  : KIND_CTRL;
			4'b1000: kind = press ? KIND_KEY   : KIND_SHIFT;
			default: kind = KIND_KEY;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= '0;
			sub_vld_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				hit_q     <= head.hit;
				sub_vld_q <= 1'b0;
			end else if (adv) begin
				hit_q     <= hit_nxt;
				sub_vld_q <= (rest != '0);
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			press_q <= head.press;
		end
		if (adv) begin
			sub_q      <= rest;
			out_kind_q <= kind;
			out_code_q <= (kind == KIND_KEY) ? (code[7:0] & STD_MASK[7:0]) : 8'd0;
			out_down_q <= press;
			out_last_q <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_kind  = out_kind_q;
	assign out_code  = out_code_q;
	assign out_down  = out_down_q;
	assign out_last  = out_last_q;

endmodule

FILE: hw/rtl/matrix_keypad_event_generator.sv
`timescale 1ns / 1ps

// Keypad event generator. Each slave word is one poll tick holding the return-line
// samples of three scan rows; the block keeps a seven-key pressed map and turns every
// press or release into a burst of master words (modifier downs then key down on a
// press, key up then modifier ups on a release), tlast marking the final word of the
// tick. A tick that changes no key produces no words. The front end takes one tick per
// cycle while the edge queue (FIFO_DEPTH entries) has room; the back end emits one event
// per cycle unless m_tready stalls it, up to 28 per tick. Config is to be written only
// while idle; the block itself does not enforce it. cfg_addr 0 is the layout select
// (reset 1), 1..7 are the up, down, left, right, centre, soft left and soft right code
// maps (reset 0). Release events use the map as it stands at the release.

module matrix_keypad_event_generator
	import kpd_pkg::*;
#(
	parameter int FIFO_DEPTH = 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [47:0]           s_tdata,   // row_one_lines, row_two_lines, row_three_lines
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // key_code[7:0], is_down[8], zero fill
	output logic [1:0]            m_tuser,   // event_kind
	output logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [MAP_W-1:0]      cfg_wdata
);

	// config registers
	logic     key_mode_q;
	key_map_t key_map_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_mode_q <= 1'b1;
			key_map_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_addr == REG_KEY_MODE) begin
				key_mode_q <= cfg_wdata[0];
			end else begin
				key_map_q[KEY_W'(cfg_addr - REG_MAP_BASE)] <= cfg_wdata;
			end
		end
	end

	// front: scan and edge detect
	logic                s_accept;
	logic                push;
	edge_word_t          push_word;
	logic [NUM_KEYS-1:0] pressed;
	q_stat_t             stat;

	assign s_tready = !stat.full;
	assign s_accept = s_tvalid && s_tready;

	kpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (s_accept),
		.row_one   (s_tdata[15:0]),
		.row_two   (s_tdata[31:16]),
		.row_three (s_tdata[47:32]),
		.push      (push),
		.push_word (push_word),
		.pressed   (pressed)
	);

	// edge queue between front and back
	edge_word_t head;
	logic       pop;

	kpd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.stat      (stat)
	);

	// back: event sequencer and output register
	kind_t      out_kind;
	logic [7:0] out_code;
	logic       out_down;

	kpd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_mode  (key_mode_q),
		.key_map   (key_map_q),
		.head      (head),
		.stat      (stat),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_kind  (out_kind),
		.out_code  (out_code),
		.out_down  (out_down),
		.out_last  (m_tlast)
	);

	assign m_tdata = {7'd0, out_down, out_code};
	assign m_tuser = out_kind;

	// modifier words never carry a key code
	a_mod_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != KIND_KEY)) |-> (m_tdata[7:0] == 8'd0))
		else $error("modifier word with nonzero key code");

	// a press burst always ends on the key down, so a modifier down is never last
	a_mod_down_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser != KIND_KEY) && m_tdata[8]) |-> !m_tlast)
		else $error("modifier down closes a tick");

	// pressed map moves only on an accepted tick
	a_pressed_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!s_accept |=> $stable(pressed))
		else $error("pressed map changed without a tick");

	// queue is never written while full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !stat.full)
		else $error("edge queue overflow");

endmodule

FILE: tb/matrix_keypad_event_generator_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the keypad event generator.
// Each slave word is one poll tick with three rows of return lines. A local predictor
// keeps its own pressed map, layout select and code maps. It turns each accepted tick
// into the burst of master words the block should emit. The monitor checks every master
// word against the oldest word still owed.
module matrix_keypad_event_generator_test
	import kpd_pkg::*;
();

	localparam int LIMIT_CYCLES  = 300000;
	localparam int HOLD_CYCLES   = 400;  // long event-side hold-off, fills the edge queue
	localparam int SETTLE_CYCLES = 64;   // > one full 28-event tick

	// modifier request bits inside a 16-bit mapped code
	localparam int MOD_SHIFT = 15;
	localparam int MOD_FUNC  = 14;
	localparam int MOD_CTRL  = 13;

	// buttons in scan test order: up, right, left, down, centre, soft left, soft right
	localparam logic [6:0][7:0] BUTTON_PATTERN = {
		8'h41, 8'h81, 8'h30, 8'h28, 8'h24, 8'h22, 8'h21
	};
	// pressed-map bit (and code map number) of each button above
	localparam logic [6:0][2:0] BUTTON_KEY = {
		3'd6, 3'd5, 3'd4, 3'd1, 3'd2, 3'd3, 3'd0
	};

	typedef struct packed {
		kind_t      kind;
		logic [7:0] code;
		logic       down;
		logic       last;
	} key_event_t;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [47:0]           s_tdata   = '0;  // row_one_lines, row_two_lines, row_three_lines
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [15:0]           m_tdata;         // key_code[7:0], is_down[8], zero fill
	logic [1:0]            m_tuser;         // event_kind
	logic                  m_tlast;
	logic                  cfg_we    = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
	logic [MAP_W-1:0]      cfg_wdata = '0;

	// predictor state, mirrors the block's registers
	logic              layout_sel = 1'b1;
	logic [6:0][31:0]  code_map   = '0;
	logic [6:0]        keys_down  = '0;

	logic [47:0] pending_ticks[$];    // ticks not yet offered
	key_event_t  expected_events[$];  // event words owed by the block, oldest first
	key_event_t  head_event;

	int words_offered  = 0;
	int words_taken    = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int hold_requests  = 0;
	int holds_done     = 0;
	int hold_left      = 0;
	int error_count    = 0;
	int events_checked = 0;
	int longest_burst  = 0;
	int cycle_count    = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	matrix_keypad_event_generator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	task automatic report_mismatch(input string what);
		error_count++;
		$display("%0d ns  mismatch: %s", $time, what);
	endtask

	function automatic void owe_event(input kind_t kind, input logic [7:0] code,
			input logic down);
		expected_events.push_back('{kind: kind, code: code, down: down, last: 1'b0});
	endfunction

	// One tick: build the scan code, then walk the buttons in test order.
	// Press: modifier downs (shift, ctrl, func) then key down.
	// Release: key up then modifier ups (func, ctrl, shift), code as mapped right now.
	task automatic predict_events(input logic [47:0] rows);
		logic [15:0] scan;
		logic [15:0] code;
		logic [2:0]  key;
		logic        hit;
		int          first;
		key_event_t  tail;
		first = expected_events.size();
		scan = '0;
		// last nonzero row wins, its marker bit is row+5
		for (int r = 0; r < 3; r++)
			if (rows[16*r +: 16] != '0) scan = rows[16*r +: 16] | (16'h0020 << r);
		for (int i = 0; i < NUM_KEYS; i++) begin
			key  = BUTTON_KEY[i];
			hit  = (scan[7:0] & BUTTON_PATTERN[i]) == BUTTON_PATTERN[i];
			code = layout_sel ? code_map[key][31:16] : code_map[key][15:0];
			if (keys_down[key] && !hit) begin
				owe_event(KIND_KEY, code[7:0], 1'b0);
				if (code[MOD_FUNC])  owe_event(KIND_FUNC, 8'h00, 1'b0);
				if (code[MOD_CTRL])  owe_event(KIND_CTRL, 8'h00, 1'b0);
				if (code[MOD_SHIFT]) owe_event(KIND_SHIFT, 8'h00, 1'b0);
				keys_down[key] = 1'b0;
			end else if (!keys_down[key] && hit) begin
				if (code[MOD_SHIFT]) owe_event(KIND_SHIFT, 8'h00, 1'b1);
				if (code[MOD_CTRL])  owe_event(KIND_CTRL, 8'h00, 1'b1);
				if (code[MOD_FUNC])  owe_event(KIND_FUNC, 8'h00, 1'b1);
				owe_event(KIND_KEY, code[7:0], 1'b1);
				keys_down[key] = 1'b1;
			end
		end
		// tlast goes on the final word of the tick; an edgeless tick owes nothing
		if (expected_events.size() > first) begin
			tail = expected_events.pop_back();
			tail.last = 1'b1;
			expected_events.push_back(tail);
			if (expected_events.size() - first > longest_burst)
				longest_burst = expected_events.size() - first;
		end
	endtask

	// Monitor: samples at the rising edge, predicts on slave words, checks master words.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_events(s_tdata);
				words_taken <= words_taken + 1;
			end
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("event word %h kind %0d last %b with none owed",
						m_tdata, m_tuser, m_tlast));
				end else begin
					head_event = expected_events.pop_front();
					events_checked++;
					if (m_tuser != head_event.kind)
						report_mismatch($sformatf("event %0d kind %0d, want %0d",
							events_checked, m_tuser, head_event.kind));
					if (m_tdata[7:0] != head_event.code)
						report_mismatch($sformatf("event %0d key code %h, want %h",
							events_checked, m_tdata[7:0], head_event.code));
					if (m_tdata[8] != head_event.down)
						report_mismatch($sformatf("event %0d down %b, want %b",
							events_checked, m_tdata[8], head_event.down));
					if (m_tlast != head_event.last)
						report_mismatch($sformatf("event %0d last %b, want %b",
							events_checked, m_tlast, head_event.last));
				end
			end
		end
	end

	// Driver: holds a word until taken, then offers the next one unless it idles.
	always @(negedge clk) begin
		if (s_tvalid && words_taken != words_offered) begin
			// word still waiting for s_tready
		end else if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
			s_tdata       <= pending_ticks.pop_front();
			s_tvalid      <= 1'b1;
			words_offered <= words_offered + 1;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Event side: random stalls, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			m_tready   <= 1'b0;
			hold_left  <= HOLD_CYCLES;
			holds_done <= holds_done + 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Cycle limit; a hang ends here.
	initial begin
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Cycle limit hit with %0d events still owed", expected_events.size());
		$display("*** FAILED ***");
		$finish;
	end

	// Config writes happen only with the block idle; the predictor follows at once.
	task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [MAP_W-1:0] value);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_addr  = addr;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we = 1'b0;
		if (addr == REG_KEY_MODE) layout_sel = value[0];
		else code_map[addr - REG_MAP_BASE] = value;
	endtask

	task automatic load_maps(input logic mode, input bit all_ones);
		for (int k = 0; k < NUM_KEYS; k++)
			write_reg(CFG_ADDR_W'(REG_MAP_BASE + k),
				all_ones ? {MAP_W{1'b1}} : MAP_W'($urandom()));
		write_reg(REG_KEY_MODE, MAP_W'(mode));
	endtask

	// Wait until every tick is taken and every event word has come, then let a
	// possible edgeless tick finish in the block.
	task automatic settle();
		do @(posedge clk);
		while (pending_ticks.size() != 0 || words_taken != words_offered ||
			expected_events.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic add_tick(input logic [15:0] one, input logic [15:0] two,
			input logic [15:0] three);
		pending_ticks.push_back({three, two, one});
	endtask

	// Mostly plausible keypad reads: one active row with a few low lines set, the rows
	// before it as noise; sometimes everything released or all 48 bits random.
	function automatic logic [47:0] random_tick();
		logic [2:0][15:0] rows;
		int               top;
		rows = '0;
		case ($urandom_range(0, 9))
			0: ;  // every key let go
			1: begin
				rows[0] = 16'($urandom());
				rows[1] = 16'($urandom());
				rows[2] = 16'($urandom());
			end
			default: begin
				top = $urandom_range(0, 2);
				if ($urandom_range(0, 1)) rows[top] = 16'h0001 << $urandom_range(0, 7);
				else rows[top] = 16'($urandom_range(1, 255));
				if ($urandom_range(0, 3) == 0) rows[top][15:8] = 8'($urandom());
				for (int r = 0; r < top; r++)
					if ($urandom_range(0, 1)) rows[r] = 16'($urandom());
			end
		endcase
		return rows;
	endfunction

	task automatic queue_random(input int count);
		for (int n = 0; n < count; n++) pending_ticks.push_back(random_tick());
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset layout (select 1, all maps zero): plain key codes 0, no modifiers
		add_tick(16'h0001, 16'h0000, 16'h0000);
		add_tick(16'h0000, 16'h0000, 16'h0000);
		settle();

		// every code asks for every modifier, key code ff; layout 0
		load_maps(1'b0, 1'b1);
		add_tick(16'h0001, 16'h0000, 16'h0000);  // up
		add_tick(16'h0002, 16'h0000, 16'h0000);  // right, up released
		add_tick(16'h0004, 16'h0000, 16'h0000);  // left
		add_tick(16'h0008, 16'h0000, 16'h0000);  // down
		add_tick(16'h0010, 16'h0000, 16'h0000);  // centre
		add_tick(16'h0000, 16'h0000, 16'h0001);  // soft left via row three
		add_tick(16'h0000, 16'h0001, 16'h0000);  // soft right via row two
		add_tick(16'hFFFF, 16'hFFFF, 16'hFFFF);  // other six down: 24 words
		add_tick(16'hFFFF, 16'hFFFF, 16'hFFFF);  // nothing changes, no words
		add_tick(16'h0000, 16'h0000, 16'h0000);  // all seven up: 28 words
		add_tick(16'hFF00, 16'h0000, 16'h0000);  // high lines only, no button
		add_tick(16'h0001, 16'h0002, 16'h0000);  // row two overrides row one
		add_tick(16'h0000, 16'h0021, 16'h0000);  // line 5 aliases the row one marker
		add_tick(16'h0001, 16'h0000, 16'h0000);  // up held across a map change
		settle();
		// release uses the code mapped at release time: ctrl + func, key 55
		write_reg(REG_MAP_BASE, 32'h0000_6055);
		add_tick(16'h0000, 16'h0000, 16'h0000);
		settle();

		// random phase 1: sender idles a third, receiver two thirds, one long hold-off
		load_maps(1'b1, 1'b0);
		send_idle_pct = 33;
		recv_idle_pct = 63;
		queue_random(33);
		hold_requests = hold_requests + 1;
		settle();

		// random phase 2: the other way round, layout 0
		load_maps(1'b0, 1'b0);
		send_idle_pct = 63;
		recv_idle_pct = 33;
		queue_random(33);
		settle();

		// random phase 3: no idling on either side
		load_maps(1'b1, 1'b0);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(34);
		settle();

		if (expected_events.size() != 0)
			report_mismatch($sformatf("%0d events never came", expected_events.size()));
		$display("Covered %0d ticks and %0d event words over both layouts, %0d words at most",
			words_taken, events_checked, longest_burst);
		$display("per tick, with stalls on both sides and a hold-off that backed up the ticks.");
		if (error_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/kpd_pkg.sv
hw/rtl/kpd_front.sv
hw/rtl/kpd_fifo.sv
hw/rtl/kpd_back.sv
hw/rtl/matrix_keypad_event_generator.sv
tb/matrix_keypad_event_generator_test.sv
